@@ rtl/abrf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// abrf_pkg
// Shared types and default sizes for the absolute binary record framer.
// ----------------------------------------------------------------------------
package abrf_pkg;

	localparam int WORD_W = 16;
	localparam int BLOCK_WORDS_DEF = 27;
	localparam int TRAILER_WORDS_DEF = 10;

	typedef logic [WORD_W-1:0] word_t;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

endpackage
`default_nettype wire

@@ rtl/abrf_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// abrf_in_if / abrf_out_if
// Valid/ready channels for input items and for output record words.
// ----------------------------------------------------------------------------
interface abrf_in_if;
	import abrf_pkg::*;

	logic  valid;
	logic  ready;
	logic  kind;
	word_t address;
	word_t data;

	modport source (output valid, output kind, output address, output data, input ready);
	modport sink (input valid, input kind, input address, input data, output ready);
endinterface

interface abrf_out_if;
	import abrf_pkg::*;

	logic  valid;
	logic  ready;
	word_t record_word;
	logic  last;

	modport source (output valid, output record_word, output last, input ready);
	modport sink (input valid, input record_word, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/abrf_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// abrf_ram
// Generic single-write, single-read RAM with a registered, enabled read port.
// ----------------------------------------------------------------------------
module abrf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 27,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/absolute_binary_record_framer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// absolute_binary_record_framer
// Packs address/data items into absolute binary loader records with a
// header, start address, data words and checksum, plus a zero trailer.
// ----------------------------------------------------------------------------
// A data word that is only buffered keeps the block idle; it is ready again next cycle.
// A record of N words leaves as N+3 transactions, one per cycle while the output is not stalled.
// A word that breaks the run is placed in the cycle after the checksum has been loaded.
// A finish item adds TRAILER_WORDS zero words at one per cycle unless the output stalls; the
// output register holds a waiting word while the sequencer stays stalled on the output side.
// Reset clears the count, start address and sequencer; the buffer RAM is not cleared.
module absolute_binary_record_framer #(
	parameter int BLOCK_WORDS = abrf_pkg::BLOCK_WORDS_DEF,
	parameter int TRAILER_WORDS = abrf_pkg::TRAILER_WORDS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	abrf_in_if.sink    items,
	abrf_out_if.source words
);
	import abrf_pkg::*;

	localparam int AW = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
	localparam int CW = $clog2(BLOCK_WORDS + 1);
	localparam int TRW = (TRAILER_WORDS > 1) ? $clog2(TRAILER_WORDS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_ADDR,
		ST_DATA,
		ST_CHK,
		ST_PLACE,
		ST_TRAIL
	} state_t;

	state_t          state_q;
	logic            kind_q;
	logic            place_q;
	word_t           addr_q;
	word_t           data_q;
	word_t           start_q;
	word_t           sum_q;
	logic [CW-1:0]   cnt_q;
	logic [AW-1:0]   rd_idx_q;
	logic [TRW-1:0]  tr_q;
	logic            out_v_q;
	word_t           out_word_q;
	logic            out_last_q;

	logic            accept;
	logic            adv;
	logic            out_load;
	logic            mismatch;
	logic            place_go;
	word_t           pl_addr;
	word_t           pl_data;
	word_t           pl_sum;
	logic [CW-1:0]   pl_cnt;
	logic            pl_full;
	logic            last_idx;
	logic            tr_last;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	word_t           ram_rdata;

	assign items.ready = (state_q == ST_IDLE);
	assign accept = items.valid && items.ready;
	assign adv = !out_v_q || words.ready;
	assign out_load = adv && ((state_q == ST_HDR) || (state_q == ST_ADDR) ||
		(state_q == ST_DATA) || (state_q == ST_CHK) || (state_q == ST_TRAIL));

	assign words.valid = out_v_q;
	assign words.record_word = out_word_q;
	assign words.last = out_last_q;

	assign mismatch = (cnt_q != '0) &&
		(word_t'(start_q + word_t'(cnt_q)) != items.address);

	assign place_go = (accept && items.kind == KIND_DATA && !mismatch) ||
		(state_q == ST_PLACE);
	assign pl_addr = (state_q == ST_PLACE) ? addr_q : items.address;
	assign pl_data = (state_q == ST_PLACE) ? data_q : items.data;
	assign pl_sum = (cnt_q == '0) ? word_t'(pl_addr + pl_data) : word_t'(sum_q + pl_data);
	assign pl_cnt = cnt_q + CW'(1);
	assign pl_full = (pl_cnt == CW'(BLOCK_WORDS));

	assign last_idx = (CW'(rd_idx_q) == cnt_q - CW'(1));
	assign tr_last = (tr_q == TRW'(TRAILER_WORDS - 1));

	always_comb begin
		ram_re = 1'b0;
		ram_raddr = '0;
		if (state_q == ST_HDR && adv) begin
			ram_re = 1'b1;
		end else if (state_q == ST_DATA && adv && !last_idx) begin
			ram_re = 1'b1;
			ram_raddr = rd_idx_q + AW'(1);
		end
	end

	abrf_ram #(
		.WIDTH(WORD_W),
		.DEPTH(BLOCK_WORDS)
	) u_buffer (
		.clk  (clk),
		.we   (place_go),
		.waddr(cnt_q[AW-1:0]),
		.wdata(pl_data),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= KIND_DATA;
			place_q <= 1'b0;
			addr_q <= '0;
			data_q <= '0;
			start_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			rd_idx_q <= '0;
			tr_q <= '0;
			out_v_q <= 1'b0;
			out_word_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (words.ready) begin
				out_v_q <= 1'b0;
			end
			if (place_go) begin
				start_q <= (cnt_q == '0) ? pl_addr : start_q;
				sum_q <= pl_sum;
				cnt_q <= pl_cnt;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q <= items.kind;
						addr_q <= items.address;
						data_q <= items.data;
						place_q <= 1'b0;
						tr_q <= '0;
						if (items.kind == KIND_FINISH) begin
							if (cnt_q != '0) begin
								state_q <= ST_HDR;
							end else if (TRAILER_WORDS > 0) begin
								state_q <= ST_TRAIL;
							end
						end else if (mismatch) begin
							place_q <= 1'b1;
							state_q <= ST_HDR;
						end else if (pl_full) begin
							state_q <= ST_HDR;
						end
					end
				end
				ST_HDR: begin
					if (adv) begin
						out_word_q <= {8'(cnt_q), 8'h00};
						out_last_q <= 1'b0;
						rd_idx_q <= '0;
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					if (adv) begin
						out_word_q <= start_q;
						out_last_q <= 1'b0;
						state_q <= ST_DATA;
					end
				end
				ST_DATA: begin
					if (adv) begin
						out_word_q <= ram_rdata;
						out_last_q <= 1'b0;
						if (last_idx) begin
							state_q <= ST_CHK;
						end else begin
							rd_idx_q <= rd_idx_q + AW'(1);
						end
					end
				end
				ST_CHK: begin
					if (adv) begin
						out_word_q <= sum_q;
						out_last_q <= !(kind_q == KIND_FINISH && TRAILER_WORDS > 0);
						cnt_q <= '0;
						if (kind_q == KIND_FINISH) begin
							state_q <= (TRAILER_WORDS > 0) ? ST_TRAIL : ST_IDLE;
						end else if (place_q) begin
							state_q <= ST_PLACE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_PLACE: begin
					place_q <= 1'b0;
					state_q <= pl_full ? ST_HDR : ST_IDLE;
				end
				ST_TRAIL: begin
					if (adv) begin
						out_word_q <= '0;
						out_last_q <= tr_last;
						if (tr_last) begin
							state_q <= ST_IDLE;
						end else begin
							tr_q <= tr_q + TRW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> cnt_q < CW'(BLOCK_WORDS))
		else $error("buffer count reached a full block while idle");

	a_finish_flush: assert property (@(posedge clk) disable iff (!arst_n)
		accept && items.kind == KIND_FINISH && cnt_q != '0 |=> state_q == ST_HDR)
		else $error("finish with pending words did not start a record");

	a_read_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DATA |-> CW'(rd_idx_q) < cnt_q)
		else $error("buffer read beyond the pending words");

	a_place_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PLACE |-> cnt_q == '0)
		else $error("deferred word placed into a non-empty buffer");

endmodule
`default_nettype wire
